FILE: rtl/core/ptt_pkg.sv
// Package for the properties text tokenizer: parse modes, result kinds,
// character codes and the tokenizer state record. No dependencies.
package ptt_pkg;

  // Parse modes; the codes above MODE_VALUE are never stored.
  typedef enum logic [2:0] {
    MODE_LINE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_KEY     = 3'd2,
    MODE_BEFORE  = 3'd3,
    MODE_AFTER   = 3'd4,
    MODE_VALUE   = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  localparam logic CMD_CHAR  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;

  typedef struct packed {
    mode_e mode;
    logic  esc;
    logic  cont_skip;
  } state_t;

  localparam state_t STATE_RESET = '{mode: MODE_LINE, esc: 1'b0, cont_skip: 1'b0};

  typedef struct packed {
    logic       emit;
    kind_e      kind;
    logic [7:0] out_char;
  } result_t;

endpackage

FILE: rtl/core/ptt_if.sv
// Valid/ready channel interfaces for the tokenizer's input and result streams.
// Stand-alone; no package needed.
interface ptt_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] ch;

  modport source (output valid, output cmd, output ch, input ready);
  modport sink   (input valid, input cmd, input ch, output ready);
endinterface

interface ptt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_char;

  modport source (output valid, output kind, output out_char, input ready);
  modport sink   (input valid, input kind, input out_char, output ready);
endinterface

FILE: rtl/core/ptt_decode.sv
// Next-state and result decode for one character of properties text.
// Purely combinational; depends on ptt_pkg.
module ptt_decode (
  input  ptt_pkg::state_t  cur_i,
  input  logic             cmd_i,
  input  logic [7:0]       ch_i,
  output ptt_pkg::state_t  nxt_o,
  output ptt_pkg::result_t res_o
);
  import ptt_pkg::*;

  logic       is_eol;
  logic       is_space;
  logic       is_sep;
  logic       pair_open;
  logic [7:0] esc_char;

  assign is_eol    = (ch_i == CH_CR) || (ch_i == CH_LF);
  assign is_space  = (ch_i == CH_SPACE) || (ch_i == CH_TAB) || (ch_i == CH_FF);
  assign is_sep    = (ch_i == CH_EQ) || (ch_i == CH_COLON);
  assign pair_open = (cur_i.mode == MODE_KEY) || (cur_i.mode == MODE_BEFORE) ||
                     (cur_i.mode == MODE_AFTER) || (cur_i.mode == MODE_VALUE);

  always_comb begin
    unique case (ch_i)
      CH_LOW_R: esc_char = CH_CR;
      CH_LOW_N: esc_char = CH_LF;
      CH_LOW_T: esc_char = CH_TAB;
      CH_LOW_F: esc_char = CH_FF;
      default:  esc_char = ch_i;
    endcase
  end

  always_comb begin
    nxt_o = cur_i;
    res_o = '{emit: 1'b0, kind: KIND_KEY, out_char: CH_NUL};

    if (cmd_i == CMD_FLUSH || ch_i == CH_NUL) begin
      // End of input: close any open pair and drop a lone backslash.
      if (pair_open) begin
        res_o = '{emit: 1'b1, kind: KIND_END, out_char: CH_NUL};
      end
      nxt_o = STATE_RESET;
    end else if (cur_i.mode == MODE_COMMENT) begin
      if (is_eol) begin
        nxt_o.mode = MODE_LINE;
      end
    end else if (cur_i.cont_skip && (is_eol || is_space)) begin
      // Still swallowing the blanks after a continued line.
    end else begin
      nxt_o.cont_skip = 1'b0;
      if (cur_i.esc) begin
        nxt_o.esc = 1'b0;
        if (is_eol) begin
          nxt_o.cont_skip = 1'b1;
        end else begin
          unique case (cur_i.mode)
            MODE_KEY: begin
              res_o = '{emit: 1'b1, kind: KIND_KEY, out_char: esc_char};
            end
            MODE_BEFORE, MODE_AFTER, MODE_VALUE: begin
              nxt_o.mode = MODE_VALUE;
              res_o = '{emit: 1'b1, kind: KIND_VALUE, out_char: esc_char};
            end
            default: begin
              nxt_o.mode = MODE_KEY;
              res_o = '{emit: 1'b1, kind: KIND_KEY, out_char: esc_char};
            end
          endcase
        end
      end else if (ch_i == CH_BSLASH) begin
        nxt_o.esc = 1'b1;
      end else begin
        unique case (cur_i.mode)
          MODE_KEY: begin
            if (is_sep) begin
              nxt_o.mode = MODE_AFTER;
            end else if (is_space) begin
              nxt_o.mode = MODE_BEFORE;
            end else if (is_eol) begin
              nxt_o.mode = MODE_LINE;
              res_o = '{emit: 1'b1, kind: KIND_END, out_char: CH_NUL};
            end else begin
              res_o = '{emit: 1'b1, kind: KIND_KEY, out_char: ch_i};
            end
          end
          MODE_BEFORE: begin
            if (is_sep) begin
              nxt_o.mode = MODE_AFTER;
            end else if (is_space) begin
              nxt_o.mode = MODE_BEFORE;
            end else if (is_eol) begin
              nxt_o.mode = MODE_LINE;
              res_o = '{emit: 1'b1, kind: KIND_END, out_char: CH_NUL};
            end else begin
              nxt_o.mode = MODE_VALUE;
              res_o = '{emit: 1'b1, kind: KIND_VALUE, out_char: ch_i};
            end
          end
          MODE_AFTER: begin
            if (is_space) begin
              nxt_o.mode = MODE_AFTER;
            end else if (is_eol) begin
              nxt_o.mode = MODE_LINE;
              res_o = '{emit: 1'b1, kind: KIND_END, out_char: CH_NUL};
            end else begin
              nxt_o.mode = MODE_VALUE;
              res_o = '{emit: 1'b1, kind: KIND_VALUE, out_char: ch_i};
            end
          end
          MODE_VALUE: begin
            if (is_eol) begin
              nxt_o.mode = MODE_LINE;
              res_o = '{emit: 1'b1, kind: KIND_END, out_char: CH_NUL};
            end else begin
              res_o = '{emit: 1'b1, kind: KIND_VALUE, out_char: ch_i};
            end
          end
          default: begin
            if (is_eol || is_space) begin
              nxt_o.mode = MODE_LINE;
            end else if (is_sep) begin
              nxt_o.mode = MODE_AFTER;
            end else if (ch_i == CH_BANG || ch_i == CH_HASH) begin
              nxt_o.mode = MODE_COMMENT;
            end else begin
              nxt_o.mode = MODE_KEY;
              res_o = '{emit: 1'b1, kind: KIND_KEY, out_char: ch_i};
            end
          end
        endcase
      end
    end
  end

endmodule

FILE: rtl/core/properties_text_tokenizer_top.sv
// Properties text tokenizer: one character per cycle. A request is decoded from
// the input register and its result is offered from the output register.
// Throughput is one request per cycle while the output drains; a stalled output
// holds the input register and so the input channel.
// Reset (rst_ni low, asynchronous) empties both registers and puts the parser
// in line-start mode with no escape or continuation pending.
module properties_text_tokenizer_top (
  input logic      clk_i,
  input logic      rst_ni,
  ptt_in_if.sink   in_i,
  ptt_out_if.source out_o
);
  import ptt_pkg::*;

  // Input register: holds one accepted request until the decode consumes it.
  logic       in_valid_q, in_valid_d;
  logic       in_cmd_q;
  logic [7:0] in_ch_q;

  // Parser state, updated once per consumed request.
  state_t     state_q, state_d;

  // Result register towards the output channel.
  logic       out_valid_q, out_valid_d;
  kind_e      out_kind_q;
  logic [7:0] out_char_q;

  result_t    res;
  logic       out_free;
  logic       consume;
  logic       in_fire;

  ptt_decode u_decode (
    .cur_i (state_q),
    .cmd_i (in_cmd_q),
    .ch_i  (in_ch_q),
    .nxt_o (state_d),
    .res_o (res)
  );

  // The result slot is free when empty or being taken this cycle, so a
  // request can be consumed every cycle while the output keeps draining.
  assign out_free = !out_valid_q || out_o.ready;
  assign consume  = in_valid_q && out_free;

  // A new request enters whenever the input register is empty or moves on.
  assign in_i.ready = !in_valid_q || consume;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (consume) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (consume) begin
      out_valid_d = res.emit;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= STATE_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (consume) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_cmd_q <= in_i.cmd;
      in_ch_q  <= in_i.ch;
    end
    if (consume && res.emit) begin
      out_kind_q <= res.kind;
      out_char_q <= res.out_char;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.kind     = out_kind_q;
  assign out_o.out_char = out_char_q;

endmodule
